FILE: rtl/mdt_pkg.sv
package mdt_pkg;

  localparam int BYTE_W = 8;

  // controls common to every window cell
  typedef struct packed {
    logic shift;   // take the neighbor's byte and valid bit
    logic clear;   // drop the held byte
  } cell_ctrl_t;

endpackage

FILE: rtl/mdt_cell.sv
module mdt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  mdt_pkg::cell_ctrl_t        ctrl,
  input  logic                       pop,
  input  logic [mdt_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_valid,
  input  logic                       in_range,
  input  logic [mdt_pkg::BYTE_W-1:0] key,
  output logic [mdt_pkg::BYTE_W-1:0] held_byte,
  output logic                       held_valid,
  output logic                       match
);

  // compare the byte this cell holds after a shift
  assign match = (in_byte == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ctrl.clear) begin
      held_valid <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= in_valid & in_range;
    end else if (pop) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held_byte <= in_byte;
    end
  end

endmodule

FILE: rtl/multibyte_delimiter_tokenizer.sv
// Splits a byte stream into tokens at the leftmost, non-overlapping
// occurrences of a delimiter of 1 to MAX_DELIM bytes (set through the
// configuration port: register 0 is the length, register 1 the packed
// delimiter bytes, first byte in bits 7..0; writing the length empties the
// window). Results leave one per cycle, while out_stall is low, through a
// single output register: token bytes (byte_valid), token ends (token_end)
// and, at the end of a source, a final token end (final_token); last_result
// marks the last result of each input item. A byte that both pushes out the
// oldest window byte and completes a delimiter gives that byte and then the
// token end; an item with end_of_source then gives each byte still held in
// the window, oldest first, and last the final token end. The window is a
// row of MAX_DELIM cells that shift one place per byte that completes no
// delimiter and compare against the delimiter in parallel. The next item is
// taken in the cycle that the current one finishes, so bytes run at one per
// cycle while the output is not stalled and no byte gives two results.
module multibyte_delimiter_tokenizer #(
  parameter int MAX_DELIM = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_source,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  token_byte,
  output logic        byte_valid,
  output logic        token_end,
  output logic        final_token,
  output logic        last_result,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LW = $clog2(MAX_DELIM + 1);
  localparam int IW = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

  // register indexes
  localparam logic REG_DELIM_LENGTH = 1'b0;
  localparam logic REG_DELIM_BYTES  = 1'b1;

  // steps of the item in work
  localparam logic [1:0] STEP_BYTE  = 2'd0;  // push the byte, check for a match
  localparam logic [1:0] STEP_MEND  = 2'd1;  // token end after a pushed-out byte
  localparam logic [1:0] STEP_FLUSH = 2'd2;  // drain the window at end of source

  // configuration
  logic [3:0]  delim_length;
  logic [63:0] delim_bytes;
  logic        cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_length <= 4'd1;
      delim_bytes  <= 64'd44;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIM_LENGTH: delim_length <= cfg_data[3:0];
        REG_DELIM_BYTES:  delim_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective length: zero acts as one, clamp at the window size
  logic [LW-1:0] len_eff;
  logic [LW-1:0] len_m1;
  logic [IW-1:0] len_idx;
  int unsigned   lenv;

  always_comb begin
    lenv = 32'(delim_length);
    if (lenv == 0) lenv = 1;
    if (lenv > MAX_DELIM) lenv = MAX_DELIM;
    len_eff = lenv[LW-1:0];
  end

  assign len_m1  = len_eff - 1'b1;
  assign len_idx = len_m1[IW-1:0];

  // item in work
  logic       cur_valid;
  logic [7:0] cur_byte;
  logic       cur_has;
  logic       cur_fin;
  logic [1:0] step;
  logic [1:0] step_next;
  logic       done;
  logic       accept;

  assign in_stall = cur_valid & ~done;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= STEP_BYTE;
    end else if (accept) begin
      cur_valid <= 1'b1;
      step      <= STEP_BYTE;
    end else begin
      if (done) cur_valid <= 1'b0;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= data_byte;
      cur_has  <= has_byte;
      cur_fin  <= end_of_source;
    end
  end

  // window cells, cell 0 holds the newest byte
  logic [7:0]           cell_byte [MAX_DELIM];
  logic [7:0]           cell_key  [MAX_DELIM];
  logic [7:0]           chain_byte[MAX_DELIM];
  logic [MAX_DELIM-1:0] win_valid;
  logic [MAX_DELIM-1:0] chain_valid;
  logic [MAX_DELIM-1:0] in_range;
  logic [MAX_DELIM-1:0] cell_match;
  logic [MAX_DELIM-1:0] top;
  logic [MAX_DELIM-1:0] pop;
  mdt_pkg::cell_ctrl_t  ctrl;

  // each cell compares against the delimiter byte at its age from the oldest
  always_comb begin
    for (int j = 0; j < MAX_DELIM; j++) begin
      in_range[j] = (j < int'(len_eff));
      if (in_range[j]) begin
        cell_key[j] = 8'(delim_bytes >> (8 * (int'(len_eff) - 1 - j)));
      end else begin
        cell_key[j] = 8'd0;
      end
    end
  end

  // oldest held byte: the top of the valid prefix
  always_comb begin
    for (int j = 0; j < MAX_DELIM; j++) begin
      if (j == MAX_DELIM - 1) begin
        top[j] = win_valid[j];
      end else begin
        top[j] = win_valid[j] & ~win_valid[j+1];
      end
    end
  end

  logic [7:0] oldest_byte;
  always_comb begin
    oldest_byte = 8'd0;
    for (int j = 0; j < MAX_DELIM; j++) begin
      oldest_byte = oldest_byte | (cell_byte[j] & {8{top[j]}});
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_DELIM; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign chain_byte[g]  = cur_byte;
        assign chain_valid[g] = 1'b1;
      end else begin : g_body
        assign chain_byte[g]  = cell_byte[g-1];
        assign chain_valid[g] = win_valid[g-1];
      end

      mdt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .pop        (pop[g]),
        .in_byte    (chain_byte[g]),
        .in_valid   (chain_valid[g]),
        .in_range   (in_range[g]),
        .key        (cell_key[g]),
        .held_byte  (cell_byte[g]),
        .held_valid (win_valid[g]),
        .match      (cell_match[g])
      );
    end
  endgenerate

  // window state before and after the push
  logic full;
  logic full_after;
  logic match_after;
  logic any_held;

  assign full        = win_valid[len_idx];
  assign full_after  = chain_valid[len_idx];
  assign match_after = full_after & (&(cell_match | ~in_range));
  assign any_held    = |win_valid;

  // output register
  logic       out_free;
  logic       emit;
  logic [7:0] e_byte;
  logic       e_bv;
  logic       e_end;
  logic       e_fin;
  logic       e_last;

  assign out_free = ~out_valid | ~out_stall;

  // one step of the item in work, at most one result per cycle
  always_comb begin
    emit       = 1'b0;
    e_byte     = 8'd0;
    e_bv       = 1'b0;
    e_end      = 1'b0;
    e_fin      = 1'b0;
    e_last     = 1'b0;
    done       = 1'b0;
    step_next  = step;
    ctrl.shift = 1'b0;
    ctrl.clear = cfg_we & (cfg_index == REG_DELIM_LENGTH);
    pop        = '0;
    if (cur_valid) begin
      case (step)
        STEP_BYTE: begin
          if (!cur_has) begin
            // end-only or idle item
            if (cur_fin) step_next = STEP_FLUSH;
            else         done      = 1'b1;
          end else if ((full | match_after) & ~out_free) begin
            // wait for the output register
          end else if (match_after) begin
            ctrl.clear = 1'b1;
            emit       = 1'b1;
            if (full) begin
              // pushed-out byte now, token end in STEP_MEND
              e_byte    = oldest_byte;
              e_bv      = 1'b1;
              step_next = STEP_MEND;
            end else begin
              e_end  = 1'b1;
              e_last = ~cur_fin;
              if (cur_fin) step_next = STEP_FLUSH;
              else         done      = 1'b1;
            end
          end else begin
            ctrl.shift = 1'b1;
            if (full) begin
              emit   = 1'b1;
              e_byte = oldest_byte;
              e_bv   = 1'b1;
              e_last = ~cur_fin;
            end
            if (cur_fin) step_next = STEP_FLUSH;
            else         done      = 1'b1;
          end
        end
        STEP_MEND: begin
          if (out_free) begin
            emit   = 1'b1;
            e_end  = 1'b1;
            e_last = ~cur_fin;
            if (cur_fin) step_next = STEP_FLUSH;
            else         done      = 1'b1;
          end
        end
        STEP_FLUSH: begin
          if (out_free) begin
            emit = 1'b1;
            if (any_held) begin
              // oldest byte first
              e_byte = oldest_byte;
              e_bv   = 1'b1;
              pop    = top;
            end else begin
              e_end      = 1'b1;
              e_fin      = 1'b1;
              e_last     = 1'b1;
              ctrl.clear = 1'b1;
              done       = 1'b1;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      token_byte  <= e_byte;
      byte_valid  <= e_bv;
      token_end   <= e_end;
      final_token <= e_fin;
      last_result <= e_last;
    end
  end

`ifndef SYNTHESIS
  // held bytes always form an unbroken run from the newest cell
  assert property (@(posedge clk) disable iff (rst)
    ((win_valid & (win_valid + 1'b1)) == '0))
    else $error("window valid bits not a prefix");

  // no byte is held beyond the delimiter length
  assert property (@(posedge clk) disable iff (rst)
    ((win_valid & ~in_range) == '0))
    else $error("window holds a byte beyond the delimiter length");

  // a final token end closes the item and is a token end
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_token) |-> (token_end && last_result && !byte_valid))
    else $error("malformed final token end");

  // while the token end after a pushed-out byte waits, the window is empty
  assert property (@(posedge clk) disable iff (rst)
    (cur_valid && step == STEP_MEND) |-> (!any_held && !in_range[MAX_DELIM-1] ||
      !any_held))
    else $error("window not cleared before match token end");
`endif

endmodule
